### rtl/assert_macros.svh
// Assertion macros shared by the matrix inverse RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse.
// No dependencies; used by every module of the block.
`default_nettype none
package mi3_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ENT       = 9;
  localparam int ENT_W         = 32;
  localparam int COF_W         = 64;
  localparam int DET_W         = 98;
  localparam int DMAG_W        = 97;
  localparam int QBITS         = 32;
  localparam int CF_LAT        = 6;
  localparam int LANE_LAT      = 35;
  localparam logic [ENT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ENT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [NUM_ENT-1:0][COF_W-1:0] cof;
    logic [DMAG_W-1:0]             dmag;
    logic                          dneg;
    logic                          sing;
  } cof_bus_t;

  typedef struct packed {
    logic [ENT_W-1:0] val;
    logic             clip;
  } lane_res_t;
endpackage
`default_nettype wire

### rtl/mi3_cofactor.sv
// Cofactor and determinant pipeline: nine cofactors, then the first-row
// determinant through split partial products. Depends on mi3_pkg.
`default_nettype none
module mi3_cofactor (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        en,
  input  wire logic                                        v_in,
  input  wire logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::ENT_W-1:0] a,
  output logic                                             v_out,
  output mi3_pkg::cof_bus_t                                bus
);
  localparam int CW = mi3_pkg::COF_W;
  localparam int DW = mi3_pkg::DET_W;

  logic [mi3_pkg::CF_LAT-1:0]          v_r;
  logic [8:0][CW-1:0]                  p1_r, p2_r, cof2_r, cof3_r, cof4_r, cof5_r;
  logic [2:0][mi3_pkg::ENT_W-1:0]      a0s1_r, a0s2_r;
  logic [2:0][64:0]                    pl_r;
  logic [2:0][63:0]                    ph_r;
  logic [2:0][DW-1:0]                  prod_r;
  logic [DW-1:0]                       det_r;
  mi3_pkg::cof_bus_t                   bus_r;
  logic [DW-1:0]                       det_neg;

  for (genvar g = 0; g < 9; g++) begin : g_cof
    localparam int I  = g / 3;
    localparam int J  = g % 3;
    localparam int I1 = (I + 1) % 3;
    localparam int I2 = (I + 2) % 3;
    localparam int J1 = (J + 1) % 3;
    localparam int J2 = (J + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[g]   <= $signed(a[3*I1+J1]) * $signed(a[3*I2+J2]);
        p2_r[g]   <= $signed(a[3*I1+J2]) * $signed(a[3*I2+J1]);
        cof2_r[g] <= p1_r[g] - p2_r[g];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        a0s1_r[j] <= a[j];
        a0s2_r[j] <= a0s1_r[j];
        pl_r[j]   <= $signed(a0s2_r[j]) * $signed({1'b0, cof2_r[j][31:0]});
        ph_r[j]   <= $signed(a0s2_r[j]) * $signed(cof2_r[j][63:32]);
        prod_r[j] <= $signed({{(DW-96){ph_r[j][63]}}, ph_r[j], 32'd0})
                   + $signed({{(DW-65){pl_r[j][64]}}, pl_r[j]});
      end
    end
  end

  assign det_neg = '0 - det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cof3_r     <= cof2_r;
      cof4_r     <= cof3_r;
      cof5_r     <= cof4_r;
      det_r      <= prod_r[0] + prod_r[1] + prod_r[2];
      bus_r.cof  <= cof5_r;
      bus_r.dneg <= det_r[DW-1];
      bus_r.dmag <= det_r[DW-1] ? det_neg[mi3_pkg::DMAG_W-1:0]
                                : det_r[mi3_pkg::DMAG_W-1:0];
      bus_r.sing <= (det_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[mi3_pkg::CF_LAT-2:0], v_in};
    end
  end

  assign v_out = v_r[mi3_pkg::CF_LAT-1];
  assign bus   = bus_r;
endmodule
`default_nettype wire

### rtl/mi3_div_lane.sv
// One division lane: rounds a cofactor over the determinant with a
// restoring divider of one quotient bit per stage, then saturates. Uses mi3_pkg.
`default_nettype none
module mi3_div_lane #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [mi3_pkg::COF_W-1:0]    c,
  input  wire logic [mi3_pkg::DMAG_W-1:0]   dmag,
  input  wire logic                         dneg,
  input  wire logic                         sing,
  output mi3_pkg::lane_res_t                res
);
  localparam int QB    = mi3_pkg::QBITS;
  localparam int SH    = 2 * FRAC_BITS + 1;
  localparam int NW    = mi3_pkg::COF_W + SH;
  localparam int XW    = (NW > mi3_pkg::DMAG_W ? NW : mi3_pkg::DMAG_W) + 1;
  localparam int YW    = mi3_pkg::DMAG_W + 1;
  localparam int CMINW = YW + QB + 1;
  localparam int CW    = XW > CMINW ? XW : CMINW;
  localparam int NST   = QB + 2;

  logic [CW-1:0]         r_r    [NST];
  logic [YW-1:0]         y_r    [NST];
  logic [QB-1:0]         q_r    [NST];
  logic                  ovf_r  [NST];
  logic                  neg_r  [NST];
  logic                  sing_r [NST];
  logic [mi3_pkg::COF_W-1:0] mag;
  logic [XW-1:0]         x;
  mi3_pkg::lane_res_t    res_r, res_nxt;
  logic [QB-1:0]         qf;

  assign mag = c[mi3_pkg::COF_W-1] ? ('0 - c) : c;
  assign x   = XW'({mag, {SH{1'b0}}}) + XW'(dmag);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= CW'(x);
      y_r[0]    <= {dmag, 1'b0};
      q_r[0]    <= '0;
      ovf_r[0]  <= 1'b0;
      neg_r[0]  <= (c[mi3_pkg::COF_W-1] != dneg) && (c != '0);
      sing_r[0] <= sing;
    end
  end

  // Stage one only tests whether the quotient reaches 2^32, which saturates.
  for (genvar s = 1; s < NST; s++) begin : g_stage
    localparam int K = NST - 1 - s;
    logic [CW-1:0] sub;
    logic          ge;
    assign sub = CW'(y_r[s-1]) << K;
    assign ge  = r_r[s-1] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        y_r[s]    <= y_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        sing_r[s] <= sing_r[s-1];
        if (s == 1) begin
          r_r[s]   <= r_r[s-1];
          q_r[s]   <= '0;
          ovf_r[s] <= ge;
        end else begin
          r_r[s]   <= ge ? r_r[s-1] - sub : r_r[s-1];
          q_r[s]   <= {q_r[s-1][QB-2:0], ge};
          ovf_r[s] <= ovf_r[s-1];
        end
      end
    end
  end

  assign qf = q_r[NST-1];

  always_comb begin
    res_nxt.val  = qf;
    res_nxt.clip = 1'b0;
    if (sing_r[NST-1]) begin
      res_nxt.val = '0;
    end else if (!neg_r[NST-1]) begin
      if (ovf_r[NST-1] || qf[QB-1]) begin
        res_nxt.val  = mi3_pkg::SAT_POS;
        res_nxt.clip = 1'b1;
      end
    end else begin
      if (ovf_r[NST-1] || (qf[QB-1] && (qf[QB-2:0] != '0))) begin
        res_nxt.val  = mi3_pkg::SAT_NEG;
        res_nxt.clip = 1'b1;
      end else begin
        res_nxt.val = '0 - qf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;
endmodule
`default_nettype wire

### rtl/matrix3x3_inverse.sv
// An accepted request reaches out_valid through 6 cofactor and determinant stages,
// 35 stages in each divider lane and one output register.
// Throughput: one matrix per cycle when not stalled; divider lanes are fully pipelined.
// The whole pipeline holds while a finished result is stalled at the output.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module matrix3x3_inverse #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_a00,
  input  wire logic signed [31:0] in_a01,
  input  wire logic signed [31:0] in_a02,
  input  wire logic signed [31:0] in_a10,
  input  wire logic signed [31:0] in_a11,
  input  wire logic signed [31:0] in_a12,
  input  wire logic signed [31:0] in_a20,
  input  wire logic signed [31:0] in_a21,
  input  wire logic signed [31:0] in_a22,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_inv00,
  output logic signed [31:0]      out_inv01,
  output logic signed [31:0]      out_inv02,
  output logic signed [31:0]      out_inv10,
  output logic signed [31:0]      out_inv11,
  output logic signed [31:0]      out_inv12,
  output logic signed [31:0]      out_inv20,
  output logic signed [31:0]      out_inv21,
  output logic signed [31:0]      out_inv22,
  output logic                    out_singular,
  output logic                    out_clipped
);
  localparam int LAT = mi3_pkg::LANE_LAT;

  logic                                          en, v_in, cf_v;
  logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::ENT_W-1:0] a;
  mi3_pkg::cof_bus_t                             bus;
  mi3_pkg::lane_res_t                            lres [mi3_pkg::NUM_ENT];
  logic [mi3_pkg::NUM_ENT-1:0]                   clips;
  logic [LAT-1:0]                                vl_r, sl_r;
  logic                                          out_valid_r, sing_o_r, clip_o_r;
  logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::ENT_W-1:0] inv_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign v_in     = in_valid && en;
  assign a        = {in_a22, in_a21, in_a20, in_a12, in_a11, in_a10,
                     in_a02, in_a01, in_a00};

  mi3_cofactor u_cof (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (v_in),
    .a     (a),
    .v_out (cf_v),
    .bus   (bus)
  );

  // Entry (i, j) of the inverse takes cofactor (j, i).
  for (genvar g = 0; g < mi3_pkg::NUM_ENT; g++) begin : g_lane
    localparam int I = g / 3;
    localparam int J = g % 3;
    mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en   (en),
      .c    (bus.cof[3*J+I]),
      .dmag (bus.dmag),
      .dneg (bus.dneg),
      .sing (bus.sing),
      .res  (lres[g])
    );
    assign clips[g] = lres[g].clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else if (en) begin
      vl_r <= {vl_r[LAT-2:0], cf_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl_r <= {sl_r[LAT-2:0], bus.sing};
    end
  end

  // Merge stage: gather the lanes and fold their saturation flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::NUM_ENT; k++) begin
        inv_r[k] <= lres[k].val;
      end
      sing_o_r <= sl_r[LAT-1];
      clip_o_r <= |clips;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_inv00    = inv_r[0];
  assign out_inv01    = inv_r[1];
  assign out_inv02    = inv_r[2];
  assign out_inv10    = inv_r[3];
  assign out_inv11    = inv_r[4];
  assign out_inv12    = inv_r[5];
  assign out_inv20    = inv_r[6];
  assign out_inv21    = inv_r[7];
  assign out_inv22    = inv_r[8];
  assign out_singular = sing_o_r;
  assign out_clipped  = clip_o_r;

  `MI3_ASSERT_IMP(a_sing_no_clip, out_valid && out_singular, !out_clipped, "singular and clipped")
  `MI3_ASSERT_IMP(a_sing_zero, out_valid && out_singular, (inv_r == '0), "singular not zero")
  `MI3_ASSERT_IMP(a_stall_only_full, in_stall, out_valid && out_stall, "stall without result")
  `MI3_ASSERT_NEXT(a_drain, out_valid && !out_stall && !vl_r[LAT-1], !out_valid, "result repeated")
endmodule
`default_nettype wire

### verif/tb_matrix3x3_inverse.sv
// Testbench for matrix3x3_inverse: directed matrices, then random ones, all checked per request.
// Needs mi3_pkg and the RTL of the block; expected inverses come from the directed table or a local predictor.
`default_nettype none
module tb_matrix3x3_inverse;
  localparam int FB        = mi3_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1950;
  localparam int MAX_CYC   = 600000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::ENT_W-1:0] mat_t;

  typedef struct packed {
    mat_t inv;
    logic sing;
    logic clip;
  } inv_res_t;

  typedef struct packed {
    mat_t     a;
    logic     known;
    inv_res_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mat_t in_m = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] o00, o01, o02, o10, o11, o12, o20, o21, o22;
  logic out_singular, out_clipped;

  inv_res_t pending_inv[$];
  int errors = 0;
  int cycles = 0;
  bit burst = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_m[0]), .in_a01(in_m[1]), .in_a02(in_m[2]),
    .in_a10(in_m[3]), .in_a11(in_m[4]), .in_a12(in_m[5]),
    .in_a20(in_m[6]), .in_a21(in_m[7]), .in_a22(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv00(o00), .out_inv01(o01), .out_inv02(o02),
    .out_inv10(o10), .out_inv11(o11), .out_inv12(o12),
    .out_inv20(o20), .out_inv21(o21), .out_inv22(o22),
    .out_singular(out_singular), .out_clipped(out_clipped)
  );

  function automatic mat_t diag(input logic [31:0] x);
    mat_t m;
    m = '0;
    m[0] = x;
    m[4] = x;
    m[8] = x;
    return m;
  endfunction

  function automatic mat_t fill(input logic [31:0] x);
    mat_t m;
    for (int k = 0; k < mi3_pkg::NUM_ENT; k++) m[k] = x;
    return m;
  endfunction

  // Adjugate over determinant, exact until the single rounding of each quotient.
  function automatic inv_res_t inverse_of(input mat_t a);
    logic signed [127:0] m[9];
    logic signed [127:0] cof[9];
    logic signed [127:0] det, c;
    logic [191:0] dmag, num, q;
    logic [127:0] cm;
    logic neg;
    inv_res_t r;
    int i1, i2, j1, j2;
    r = '0;
    for (int k = 0; k < 9; k++) m[k] = {{96{a[k][31]}}, a[k]};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3; i2 = (i + 2) % 3; j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        cof[3*i+j] = m[3*i1+j1] * m[3*i2+j2] - m[3*i1+j2] * m[3*i2+j1];
      end
    det = m[0] * cof[0] + m[1] * cof[1] + m[2] * cof[2];
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    dmag = {64'd0, det[127] ? -det : det};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        c = cof[3*j+i];
        cm = c[127] ? -c : c;
        num = {64'd0, cm} << (2 * FB);
        q = (2 * num + dmag) / (2 * dmag);
        neg = (c[127] != det[127]) && (c != 0);
        if (!neg) begin
          if (q > 192'h7FFF_FFFF) begin
            r.inv[3*i+j] = mi3_pkg::SAT_POS;
            r.clip = 1'b1;
          end else r.inv[3*i+j] = q[31:0];
        end else begin
          if (q > 192'h8000_0000) begin
            r.inv[3*i+j] = mi3_pkg::SAT_NEG;
            r.clip = 1'b1;
          end else r.inv[3*i+j] = -q[31:0];
        end
      end
    return r;
  endfunction

  function automatic logic [31:0] rnd_small();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic mat_t rnd_matrix();
    mat_t m;
    int kind;
    bit dup;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1: m[k] = $urandom();
        2, 3, 4, 7: m[k] = rnd_small();
        5, 6: m[k] = (k % 4 == 0) ? rnd_small() * 8 : rnd_small() / 8;
        8: m[k] = $urandom() >>> $urandom_range(0, 31);
        default: m[k] = $urandom_range(0, 16) - 8;
      endcase
    end
    // Singular by construction: one row copies or negates another.
    if (kind == 7) begin
      dup = $urandom_range(0, 1);
      for (int k = 0; k < 3; k++) m[6+k] = dup ? m[k] : -m[3+k];
    end
    return m;
  endfunction

  task automatic send_matrix(input mat_t a);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_m <= a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_item(input mat_t a, input logic known, input inv_res_t r);
    send_matrix(a);
    pending_inv.insert(pending_inv.size(), known ? r : inverse_of(a));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Result side: random stall per result, then compare against the oldest request.
  initial begin : receiver
    int stall;
    mat_t got;
    inv_res_t want;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 17);
      repeat (stall) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{o22, o21, o20, o12, o11, o10, o02, o01, o00};
      if (pending_inv.size() == 0) begin
        errors++;
        $display("%0t mismatch: result with no request outstanding, got %h", $time, got);
      end else begin
        want = pending_inv.pop_front();
        for (int k = 0; k < 9; k++)
          check_field($sformatf("inv%0d%0d", k / 3, k % 3), want.inv[k], got[k]);
        check_field("singular", want.sing, out_singular);
        check_field("clipped", want.clip, out_clipped);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t tab[$];
    inv_res_t r;
    mat_t m;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    r = '0; r.inv = diag(ONE);
    tab.insert(tab.size(), dir_row_t'{diag(ONE), 1'b1, r});
    r = '0; r.sing = 1'b1;
    tab.insert(tab.size(), dir_row_t'{fill(32'h0), 1'b1, r});
    tab.insert(tab.size(), dir_row_t'{fill(32'h7FFF_FFFF), 1'b1, r});
    tab.insert(tab.size(), dir_row_t'{fill(32'h8000_0000), 1'b1, r});
    m = diag(ONE); m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
    tab.insert(tab.size(), dir_row_t'{m, 1'b1, r});
    // Inverse of the smallest step overflows in both directions.
    r = '0; r.inv = diag(mi3_pkg::SAT_POS); r.clip = 1'b1;
    tab.insert(tab.size(), dir_row_t'{diag(32'h1), 1'b1, r});
    r = '0; r.inv = diag(mi3_pkg::SAT_NEG); r.clip = 1'b1;
    tab.insert(tab.size(), dir_row_t'{diag(32'hFFFF_FFFF), 1'b1, r});
    r = '0; r.inv = diag(32'h8000);
    tab.insert(tab.size(), dir_row_t'{diag(32'h0002_0000), 1'b1, r});
    r = '0; r.inv = diag(32'hFFFF_8000);
    tab.insert(tab.size(), dir_row_t'{diag(32'hFFFE_0000), 1'b1, r});
    r = '0;
    tab.insert(tab.size(), dir_row_t'{diag(32'h7FFF_FFFF), 1'b0, r});
    tab.insert(tab.size(), dir_row_t'{diag(32'h8000_0000), 1'b0, r});
    tab.insert(tab.size(), dir_row_t'{diag(32'h0003_0000), 1'b0, r});
    m = '0; m[1] = ONE; m[5] = 32'hFFFF_0000; m[6] = 32'h0004_0000;
    tab.insert(tab.size(), dir_row_t'{m, 1'b0, r});
    m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
          32'hFFFF_FFFF, 32'h1, 32'h0, 32'h8000_0000};
    tab.insert(tab.size(), dir_row_t'{m, 1'b0, r});
    m = '{32'h0001_8000, 32'hFFFF_4000, 32'h0000_2000, 32'h0002_0000, 32'h0000_0001,
          32'hFFFD_0000, 32'h0000_C000, 32'h0005_0000, 32'hFFFF_FFFF};
    tab.insert(tab.size(), dir_row_t'{m, 1'b0, r});
    for (int k = 0; k < 4; k++) tab.insert(tab.size(), dir_row_t'{rnd_matrix(), 1'b0, r});

    foreach (tab[t]) run_item(tab[t].a, tab[t].known, tab[t].r);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Occasional stretches where neither side idles.
      if (n % 150 == 0) burst = ($urandom_range(0, 3) == 0);
      run_item(rnd_matrix(), 1'b0, '0);
    end
    @(negedge clk) in_valid <= 1'b0;

    wait (pending_inv.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
